@@ sv/dlle_pkg.sv @@
`default_nettype none

package dlle_pkg;

    localparam int CMD_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 7;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_PAD_W    = IN_TDATA_W - VALUE_W - POS_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - COUNT_W;

    localparam logic [CMD_W-1:0] CMD_INSERT_EMPTY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT_AT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP         = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

`default_nettype wire

@@ sv/dlle_ram.sv @@
`default_nettype none

module dlle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/doubly_linked_list_engine_core.sv @@
`default_nettype none

// A bounded doubly linked list kept in a pool of POOL_NODES nodes, driven by one command word at
// a time: insert into an empty list, insert at the front or back, insert before a position, or
// dump the list from head to tail. Every insert returns one status word; a dump returns one word
// per element with tlast on the final one, or a single list_empty word. Values and links live in
// two memories with a registered read, so the rate is set by walking the link memory one node
// per cycle, and a dump waits whenever the output side stalls. A new command is taken only in
// the idle state, once the previous one has loaded its last output word. The memories are not
// cleared after reset and need no clearing pass.
module doubly_linked_list_engine_core #(
    parameter int POOL_NODES = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // value [31:0], position [38:32], zero [39]
    input  wire logic [dlle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command [2:0]
    input  wire logic [dlle_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // data_out [31:0], element_count [38:32], zero [39]
    output logic      [dlle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic      [dlle_pkg::STATUS_W-1:0]    m_axis_tuser,
    output logic                                  m_axis_tlast
);

    import dlle_pkg::*;

    localparam int AW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);
    localparam int LW = 2 * AW;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RESP    = 7'b0000010,
        S_FIX     = 7'b0000100,
        S_WALK    = 7'b0001000,
        S_MID_BEF = 7'b0010000,
        S_MID_CUR = 7'b0100000,
        S_DUMP    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [AW-1:0] nxt;
        logic [AW-1:0] prv;
    } t_link;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [AW-1:0]       r_new, n_new;
    logic [AW-1:0]       r_cur, n_cur;
    logic [AW-1:0]       r_cur_next, n_cur_next;
    logic [AW-1:0]       r_before, n_before;
    logic [CW-1:0]       r_left, n_left;
    logic                r_fix_back, n_fix_back;
    logic [STATUS_W-1:0] r_status, n_status;

    logic                r_ovalid;
    logic [VALUE_W-1:0]  r_odata;
    logic [STATUS_W-1:0] r_ostatus;
    logic                r_olast;
    logic [COUNT_W-1:0]  r_ocount;

    logic                out_load;
    logic [VALUE_W-1:0]  out_data;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;

    logic                accept;
    logic                slot_free;
    logic                is_empty;
    logic                is_full;
    logic [AW-1:0]       new_idx;
    logic [CMD_W-1:0]    in_cmd;
    logic [VALUE_W-1:0]  in_value;
    logic [POS_W-1:0]    in_pos;

    logic                         link_we;
    logic [AW-1:0]                link_waddr;
    t_link                        link_wdata;
    t_link                        link_rd;
    logic                         val_we;
    logic signed [DATA_WIDTH-1:0] val_wdata;
    logic signed [DATA_WIDTH-1:0] val_rd;
    logic [AW-1:0]                rd_addr;

    assign in_cmd   = s_axis_tuser;
    assign in_value = s_axis_tdata[VALUE_W-1:0];
    assign in_pos   = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_ovalid || m_axis_tready;
    assign is_empty      = (r_count == '0);
    assign is_full       = (r_count == CW'(POOL_NODES));
    assign new_idx       = r_count[AW-1:0];
    assign val_wdata     = DATA_WIDTH'(signed'(in_value));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_new      = r_new;
        n_cur      = r_cur;
        n_cur_next = r_cur_next;
        n_before   = r_before;
        n_left     = r_left;
        n_fix_back = r_fix_back;
        n_status   = r_status;
        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = '0;
        val_we     = 1'b0;
        rd_addr    = r_cur;
        out_load   = 1'b0;
        out_data   = '0;
        out_status = ST_OK;
        out_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_DUMP: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                rd_addr = r_head;
                                n_cur   = r_head;
                                n_left  = r_count;
                                n_state = S_DUMP;
                            end
                        end
                        CMD_INSERT_EMPTY, CMD_INSERT_FRONT, CMD_INSERT_BACK,
                        CMD_INSERT_AT: begin
                            n_state = S_RESP;
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (in_cmd == CMD_INSERT_EMPTY && !is_empty) begin
                                n_status = ST_NOT_EMPTY;
                            end else if (in_cmd == CMD_INSERT_AT &&
                                         in_pos > COUNT_W'(r_count)) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_status = ST_OK;
                                val_we   = 1'b1;
                                n_new    = new_idx;
                                n_count  = r_count + CW'(1);
                                if (in_cmd == CMD_INSERT_EMPTY || is_empty) begin
                                    n_head = new_idx;
                                    n_tail = new_idx;
                                end else if (in_cmd == CMD_INSERT_FRONT ||
                                             (in_cmd == CMD_INSERT_AT && in_pos == '0)) begin
                                    link_we    = 1'b1;
                                    link_waddr = new_idx;
                                    link_wdata = '{nxt: r_head, prv: '0};
                                    rd_addr    = r_head;
                                    n_cur      = r_head;
                                    n_fix_back = 1'b0;
                                    n_head     = new_idx;
                                    n_state    = S_FIX;
                                end else if (in_cmd == CMD_INSERT_BACK ||
                                             in_pos == COUNT_W'(r_count)) begin
                                    link_we    = 1'b1;
                                    link_waddr = new_idx;
                                    link_wdata = '{nxt: '0, prv: r_tail};
                                    rd_addr    = r_tail;
                                    n_cur      = r_tail;
                                    n_fix_back = 1'b1;
                                    n_tail     = new_idx;
                                    n_state    = S_FIX;
                                end else begin
                                    rd_addr = r_head;
                                    n_cur   = r_head;
                                    n_left  = CW'(in_pos);
                                    n_state = S_WALK;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIX: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                if (r_fix_back) begin
                    link_wdata = '{nxt: r_new, prv: link_rd.prv};
                end else begin
                    link_wdata = '{nxt: link_rd.nxt, prv: r_new};
                end
                n_state    = S_RESP;
            end
            S_WALK: begin
                if (r_left == '0) begin
                    link_we    = 1'b1;
                    link_waddr = r_new;
                    link_wdata = '{nxt: r_cur, prv: link_rd.prv};
                    n_cur_next = link_rd.nxt;
                    n_before   = link_rd.prv;
                    rd_addr    = link_rd.prv;
                    n_state    = S_MID_BEF;
                end else begin
                    n_cur   = link_rd.nxt;
                    rd_addr = link_rd.nxt;
                    n_left  = r_left - CW'(1);
                end
            end
            S_MID_BEF: begin
                link_we    = 1'b1;
                link_waddr = r_before;
                link_wdata = '{nxt: r_new, prv: link_rd.prv};
                n_state    = S_MID_CUR;
            end
            S_MID_CUR: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                link_wdata = '{nxt: r_cur_next, prv: r_new};
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = ST_OK;
                    out_data   = VALUE_W'(val_rd);
                    out_last   = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = link_rd.nxt;
                        rd_addr = link_rd.nxt;
                        n_left  = r_left - CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_new      <= n_new;
        r_cur      <= n_cur;
        r_cur_next <= n_cur_next;
        r_before   <= n_before;
        r_left     <= n_left;
        r_fix_back <= n_fix_back;
        r_status   <= n_status;
        if (out_load) begin
            r_odata   <= out_data;
            r_ostatus <= out_status;
            r_olast   <= out_last;
            r_ocount  <= COUNT_W'(r_count);
        end
    end

    dlle_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rd)
    );

    dlle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_NODES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (new_idx),
        .i_wdata (val_wdata),
        .i_raddr (rd_addr),
        .o_rdata (val_rd)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_ocount, r_odata};
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tlast  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(POOL_NODES))
        else $error("element count exceeds the pool size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)))
        else $error("element count changed by more than one");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (r_ocount == '0 && m_axis_tlast))
        else $error("list_empty word with a non-zero count or without tlast");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_left != '0 && r_left <= r_count))
        else $error("dump word counter out of range");

endmodule

`default_nettype wire

@@ dv/doubly_linked_list_engine_core_tb.sv @@
`default_nettype none

module doubly_linked_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlle_pkg::*;

    localparam int POOL_NODES = 64;
    localparam int TAIL_CYCLES = 200;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic                last;
        logic [COUNT_W-1:0]  count;
    } t_list_word;

    class list_scoreboard;
        logic [VALUE_W-1:0] list_values[$];
        t_list_word         pending_words[$];
        int                 failures;

        function new();
            failures = 0;
        endfunction

        function void queue_word(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] data,
                                 logic last);
            t_list_word w;
            w.status = status;
            w.data = data;
            w.last = last;
            w.count = COUNT_W'(list_values.size());
            pending_words.push_back(w);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            int count;
            count = list_values.size();
            if (cmd == CMD_DUMP) begin
                if (count == 0) begin
                    queue_word(ST_EMPTY, '0, 1'b1);
                end else begin
                    foreach (list_values[i]) begin
                        queue_word(ST_OK, list_values[i], i == count - 1);
                    end
                end
            end else if (cmd < CMD_DUMP) begin
                if (count >= POOL_NODES) begin
                    queue_word(ST_FULL, '0, 1'b1);
                end else if (cmd == CMD_INSERT_EMPTY && count != 0) begin
                    queue_word(ST_NOT_EMPTY, '0, 1'b1);
                end else if (cmd == CMD_INSERT_AT && pos > count) begin
                    queue_word(ST_BAD_POS, '0, 1'b1);
                end else begin
                    case (cmd)
                        CMD_INSERT_EMPTY, CMD_INSERT_FRONT: list_values.push_front(value);
                        CMD_INSERT_BACK: list_values.push_back(value);
                        default: list_values.insert(pos, value);
                    endcase
                    queue_word(ST_OK, '0, 1'b1);
                end
            end
        endfunction

        function void check_word(t_list_word got);
            t_list_word want;
            if (pending_words.size() == 0) begin
                failures++;
                $display("%0t: unexpected word, expected none, actual status=%0d data=%h last=%0d count=%0d",
                         $realtime, got.status, got.data, got.last, got.count);
                return;
            end
            want = pending_words.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.last !== want.last || got.count !== want.count) begin
                failures++;
                $display("%0t: mismatch expected status=%0d data=%h last=%0d count=%0d",
                         $realtime, want.status, want.data, want.last, want.count);
                $display("%0t:          actual   status=%0d data=%h last=%0d count=%0d",
                         $realtime, got.status, got.data, got.last, got.count);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = CMD_DUMP;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;

    logic                   idle_on = 1'b1;
    list_scoreboard         sb = new();

    doubly_linked_list_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_list_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.data = m_axis_tdata[VALUE_W-1:0];
            got.last = m_axis_tlast;
            got.count = m_axis_tdata[VALUE_W +: COUNT_W];
            sb.check_word(got);
        end
        m_axis_tready <= !(idle_on && $urandom_range(99) < 11);
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                             input logic [POS_W-1:0] pos);
        while (idle_on && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{IN_PAD_W{1'b0}}, pos, value};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, value, pos);
    endtask

    task automatic run_random(input int n_items);
        int               done;
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0] pos;
        done = 0;
        while (done < n_items) begin
            idle_on = !(done >= 120 && done < 220);
            pick = $urandom_range(99);
            value = $urandom;
            if ($urandom_range(3) != 0) begin
                pos = POS_W'($urandom_range(sb.list_values.size()));
            end else begin
                pos = POS_W'($urandom_range(127));
            end
            if (pick < 10) begin
                cmd = CMD_DUMP;
            end else if (pick < 14) begin
                cmd = CMD_INSERT_EMPTY;
            end else if (pick < 30) begin
                cmd = CMD_INSERT_FRONT;
            end else if (pick < 46) begin
                cmd = CMD_INSERT_BACK;
            end else if (pick < 95) begin
                cmd = CMD_INSERT_AT;
            end else begin
                cmd = CMD_SPARE_A + CMD_W'($urandom_range(2));
            end
            send_word(cmd, value, pos);
            if (cmd <= CMD_DUMP) begin
                done++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_DUMP, 32'h0000_0000, 7'd0);
        send_word(CMD_INSERT_AT, 32'h0000_0001, 7'd1);
        send_word(CMD_INSERT_AT, 32'h0000_0002, 7'd127);
        send_word(CMD_SPARE_A, 32'hFFFF_FFFF, 7'd0);
        send_word(CMD_SPARE_B, 32'hFFFF_FFFF, 7'd0);
        send_word(CMD_SPARE_C, 32'hFFFF_FFFF, 7'd0);
        send_word(CMD_INSERT_FRONT, 32'h8000_0000, 7'd0);
        send_word(CMD_INSERT_EMPTY, 32'h1234_5678, 7'd0);
        send_word(CMD_INSERT_BACK, 32'h7FFF_FFFF, 7'd0);
        send_word(CMD_INSERT_FRONT, 32'hFFFF_FFFF, 7'd0);
        send_word(CMD_INSERT_AT, 32'h0000_0000, 7'd1);
        send_word(CMD_INSERT_AT, 32'h5555_5555, 7'd4);
        send_word(CMD_INSERT_AT, 32'hAAAA_AAAA, 7'd0);
        send_word(CMD_INSERT_AT, 32'h0000_0003, 7'd7);
        send_word(CMD_INSERT_AT, 32'h0000_0001, 7'd3);
        send_word(CMD_DUMP, 32'h0000_0000, 7'd0);
        send_word(CMD_INSERT_AT, 32'h0000_0004, 7'd64);
        send_word(CMD_INSERT_AT, 32'hDEAD_BEEF, 7'd5);
        send_word(CMD_DUMP, 32'h0000_0000, 7'd0);

        run_random(360);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
